[design/rrqs_pkg.sv]
// ----------------------------------------------------------------------------
// rrqs_pkg
// Shared types and constants for the round-robin quantum scheduler.
// ----------------------------------------------------------------------------
package rrqs_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int LENGTH_BITS = 16;

    localparam int LEN_W = (LENGTH_BITS < 16) ? LENGTH_BITS : 16;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int TAG_W = 8;

    localparam logic [15:0] QUANTUM_RESET = 16'd5;

    localparam logic ACT_ENQUEUE = 1'b0;
    localparam logic ACT_RUN     = 1'b1;

    typedef enum logic [2:0] {
        ST_ENQUEUED = 3'd0,
        ST_REJECTED = 3'd1,
        ST_ROTATED  = 3'd2,
        ST_FINISHED = 3'd3,
        ST_EMPTY    = 3'd4
    } status_t;

    typedef struct packed {
        logic [TAG_W-1:0] tag;
        logic [LEN_W-1:0] rem;
    } entry_t;

    typedef struct packed {
        logic load;
        logic shift;
    } cell_ctrl_t;

endpackage

[design/round_robin_quantum_scheduler.sv]
// An accepted input waits in the input holding register until the output is free;
// its result is then registered into the output registers. No new input is taken
// while one is held, as that register frees only when the held item executes.
// Reset: synchronous active-low aresetn empties the queue, clears the tag
// counter and sets the quantum to 5; slot contents are not cleared.
// ----------------------------------------------------------------------------
// round_robin_quantum_scheduler
// Round-robin job queue with a configurable quantum, built as a row of slot cells
// with the head job always in the first cell.
// ----------------------------------------------------------------------------
module round_robin_quantum_scheduler (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,    // job_length
    input  logic [0:0]  s_tuser,    // action
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,    // job_tag, time_used, remaining, jobs_waiting, zero pad
    output logic [2:0]  m_tuser,    // status
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data
);
    import rrqs_pkg::*;

    logic             in_valid_reg;
    logic             action_reg;
    logic [LEN_W-1:0] len_reg;
    logic [15:0]      quantum_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [TAG_W-1:0] next_tag_reg;
    logic             m_tvalid_reg;
    status_t          status_reg;
    logic [TAG_W-1:0] tag_out_reg;
    logic [15:0]      used_reg;
    logic [15:0]      rem_out_reg;
    logic [4:0]       waiting_reg;

    entry_t     cell_q [QUEUE_DEPTH];
    cell_ctrl_t cell_ctrl [QUEUE_DEPTH];
    entry_t     load_data;
    entry_t     head;

    logic        exec_go;
    logic        full;
    logic        empty;
    logic [15:0] rem_ext;
    logic [15:0] rem_sub;
    logic        do_enq;
    logic        do_rot;
    logic        do_fin;
    status_t     status_c;
    logic [TAG_W-1:0] tag_c;
    logic [15:0] used_c;
    logic [15:0] rem_c;

    assign s_tready = !in_valid_reg;
    assign exec_go  = in_valid_reg && (!m_tvalid_reg || m_tready);
    assign head     = cell_q[0];
    assign full     = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign rem_ext  = 16'(head.rem);
    assign rem_sub  = rem_ext - quantum_reg;

    always_comb begin
        do_enq   = 1'b0;
        do_rot   = 1'b0;
        do_fin   = 1'b0;
        status_c = ST_EMPTY;
        tag_c    = '0;
        used_c   = '0;
        rem_c    = '0;
        if (action_reg == ACT_ENQUEUE) begin
            if (full) begin
                status_c = ST_REJECTED;
            end else begin
                do_enq   = exec_go;
                status_c = ST_ENQUEUED;
                tag_c    = next_tag_reg;
                rem_c    = 16'(len_reg);
            end
        end else if (!empty) begin
            tag_c = head.tag;
            if (rem_ext > quantum_reg) begin
                do_rot   = exec_go;
                status_c = ST_ROTATED;
                used_c   = quantum_reg;
                rem_c    = rem_sub;
            end else begin
                do_fin   = exec_go;
                status_c = ST_FINISHED;
                used_c   = rem_ext;
            end
        end
    end

    always_comb begin
        count_next = count_reg;
        if (do_enq) begin
            count_next = count_reg + 1'b1;
        end else if (do_fin) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_comb begin
        if (do_enq) begin
            load_data.tag = next_tag_reg;
            load_data.rem = len_reg;
        end else begin
            load_data.tag = head.tag;
            load_data.rem = LEN_W'(rem_sub);
        end
    end

    for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
        entry_t nbr;
        assign cell_ctrl[i].load  = (do_enq && (count_reg == CNT_W'(i)))
                                 || (do_rot && (count_reg == CNT_W'(i + 1)));
        assign cell_ctrl[i].shift = do_rot || do_fin;
        if (i < QUEUE_DEPTH - 1) begin : g_mid
            assign nbr = cell_q[i + 1];
        end else begin : g_end
            assign nbr = cell_q[i];
        end
        rrqs_cell u_cell (
            .aclk      (aclk),
            .ctrl      (cell_ctrl[i]),
            .load_data (load_data),
            .nbr_data  (nbr),
            .data      (cell_q[i])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            quantum_reg  <= QUANTUM_RESET;
            count_reg    <= '0;
            next_tag_reg <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                in_valid_reg <= 1'b1;
            end else if (exec_go) begin
                in_valid_reg <= 1'b0;
            end
            if (cfg_wr_en) begin
                quantum_reg <= cfg_wr_data;
            end
            count_reg <= count_next;
            if (do_enq) begin
                next_tag_reg <= next_tag_reg + 1'b1;
            end
            if (exec_go) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            action_reg <= s_tuser[0];
            len_reg    <= s_tdata[LEN_W-1:0];
        end
        if (exec_go) begin
            status_reg  <= status_c;
            tag_out_reg <= tag_c;
            used_reg    <= used_c;
            rem_out_reg <= rem_c;
            waiting_reg <= 5'(count_next);
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = status_reg;
    assign m_tdata  = {3'b000, waiting_reg, rem_out_reg, used_reg, tag_out_reg};

`ifndef SYNTH
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("Job count exceeds the queue depth.");

    a_enq_count: assert property (@(posedge aclk) disable iff (!aresetn)
        do_enq |=> (count_reg == CNT_W'($past(count_reg) + 1'b1)))
        else $error("Enqueue did not grow the job count by one.");

    a_empty_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && (status_reg == ST_EMPTY)) |-> (waiting_reg == '0))
        else $error("Empty status reported with jobs waiting.");
`endif

endmodule

[design/rrqs_cell.sv]
// ----------------------------------------------------------------------------
// rrqs_cell
// One queue slot. It loads a new entry or takes the entry of its neighbor
// nearer the tail when the queue advances.
// ----------------------------------------------------------------------------
module rrqs_cell (
    input  logic                aclk,
    input  rrqs_pkg::cell_ctrl_t ctrl,
    input  rrqs_pkg::entry_t    load_data,
    input  rrqs_pkg::entry_t    nbr_data,
    output rrqs_pkg::entry_t    data
);
    import rrqs_pkg::*;

    entry_t entry_reg;
    entry_t entry_next;

    always_comb begin
        entry_next = entry_reg;
        if (ctrl.load) begin
            entry_next = load_data;
        end else if (ctrl.shift) begin
            entry_next = nbr_data;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

    assign data = entry_reg;

endmodule

[bench/round_robin_quantum_scheduler_tb.sv]
// ----------------------------------------------------------------------------
// round_robin_quantum_scheduler_tb
// Self-checking bench for the round-robin quantum scheduler. A queued driver
// feeds enqueue and run transfers in random bursts, and the receiver stalls
// on its own pattern. A local scheduler model predicts every result, and the
// monitor compares each output transfer against the prediction. The run walks through
// several quantum settings, the extremes among them.
// ----------------------------------------------------------------------------
module round_robin_quantum_scheduler_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rrqs_pkg::*;

    localparam int CLK_PERIOD = 12;
    localparam int IDLE_LIMIT = 2000;

    typedef struct packed {
        logic        action;
        logic [15:0] length;
    } job_item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [2:0]  pad;
        logic [4:0]  waiting;
        logic [15:0] remaining;
        logic [15:0] used;
        logic [7:0]  tag;
    } sched_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;     // job_length
    logic [0:0]  s_tuser = '0;     // action
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;          // job_tag, time_used, remaining, jobs_waiting, zero pad
    logic [2:0]  m_tuser;          // status
    logic        cfg_wr_en = 1'b0;
    logic [15:0] cfg_wr_data = '0;

    round_robin_quantum_scheduler uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    initial begin
        forever #(CLK_PERIOD / 2) aclk = ~aclk;
    end

    job_item_t     job_stream[$];
    sched_result_t pending_results[$];

    logic [15:0] ring_len [QUEUE_DEPTH];
    logic [7:0]  ring_tag [QUEUE_DEPTH];
    int unsigned head_idx = 0;
    int unsigned tail_idx = 0;
    int unsigned held = 0;
    logic [7:0]  tag_next = '0;
    logic [15:0] slice = QUANTUM_RESET;

    int errors = 0;
    int inputs_taken = 0;
    int status_hits [8];
    int idle_cycles = 0;
    int gap_left = 0;
    int burst_left = 0;
    int rx_left = 1;
    job_item_t     next_job;
    sched_result_t seen;
    sched_result_t want;

    function automatic sched_result_t schedule_step(job_item_t item);
        sched_result_t r;
        logic [15:0]   left;
        logic [7:0]    t;
        r = '0;
        if (item.action == ACT_ENQUEUE) begin
            if (held >= QUEUE_DEPTH) begin
                r.status = ST_REJECTED;
            end else begin
                ring_len[tail_idx] = item.length;
                ring_tag[tail_idx] = tag_next;
                tail_idx = (tail_idx + 1) % QUEUE_DEPTH;
                held++;
                r.status = ST_ENQUEUED;
                r.tag = tag_next;
                r.remaining = item.length;
                tag_next++;
            end
        end else if (held == 0) begin
            r.status = ST_EMPTY;
        end else begin
            left = ring_len[head_idx];
            t = ring_tag[head_idx];
            r.tag = t;
            if (left > slice) begin
                // On a full ring the tail slot is the head slot itself.
                left = left - slice;
                ring_len[tail_idx] = left;
                ring_tag[tail_idx] = t;
                tail_idx = (tail_idx + 1) % QUEUE_DEPTH;
                head_idx = (head_idx + 1) % QUEUE_DEPTH;
                r.status = ST_ROTATED;
                r.used = slice;
                r.remaining = left;
            end else begin
                head_idx = (head_idx + 1) % QUEUE_DEPTH;
                held--;
                r.status = ST_FINISHED;
                r.used = left;
            end
        end
        r.waiting = 5'(held);
        return r;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (gap_left != 0) begin
                gap_left <= gap_left - 1;
                s_tvalid <= 1'b0;
            end else if (job_stream.size() != 0) begin
                next_job = job_stream.pop_front();
                s_tvalid <= 1'b1;
                s_tdata <= next_job.length;
                s_tuser <= next_job.action;
                if (burst_left <= 1) begin
                    burst_left <= ($urandom_range(0, 7) == 0) ? 40 : $urandom_range(1, 12);
                    gap_left <= ($urandom_range(0, 3) == 0) ? 0 :
                                ($urandom_range(0, 9) == 0) ? $urandom_range(10, 20) :
                                $urandom_range(1, 4);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_left <= 1;
        end else if (rx_left > 1) begin
            rx_left <= rx_left - 1;
        end else if (m_tready) begin
            m_tready <= 1'b0;
            rx_left <= ($urandom_range(0, 7) == 0) ? $urandom_range(10, 30) :
                       $urandom_range(1, 3);
        end else begin
            m_tready <= 1'b1;
            rx_left <= $urandom_range(1, 24);
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                pending_results.push_back(schedule_step(job_item_t'({s_tuser, s_tdata})));
                inputs_taken++;
            end
            if (m_tvalid && m_tready) begin
                seen = sched_result_t'({m_tuser, m_tdata});
                status_hits[seen.status]++;
                if (pending_results.size() == 0) begin
                    errors++;
                    $display("%0t: output transfer with nothing expected, actual status=%0d",
                             $time, seen.status);
                end else begin
                    want = pending_results.pop_front();
                    if (seen !== want) begin
                        errors++;
                        $display("%0t: mismatch, expected status=%0d tag=%0d used=%0d rem=%0d wait=%0d pad=%0d",
                                 $time, want.status, want.tag, want.used, want.remaining,
                                 want.waiting, want.pad);
                        $display("%0t:           actual status=%0d tag=%0d used=%0d rem=%0d wait=%0d pad=%0d",
                                 $time, seen.status, seen.tag, seen.used, seen.remaining,
                                 seen.waiting, seen.pad);
                    end
                end
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
                if (idle_cycles >= IDLE_LIMIT) begin
                    $display("%0t: no transfer for %0d cycles, %0d results outstanding",
                             $time, IDLE_LIMIT, pending_results.size());
                    $display("round_robin_quantum_scheduler verification failed");
                    $finish;
                end
            end
        end
    end

    task automatic add_job(logic action, logic [15:0] length);
        job_stream.push_back('{action: action, length: length});
    endtask

    task automatic add_random(int n);
        int          made = 0;
        int          seg_left = 0;
        int          enq_pct = 50;
        int          pick;
        logic [15:0] len;
        logic [15:0] lim;
        while (made < n) begin
            if (seg_left == 0) begin
                seg_left = $urandom_range(6, 24);
                pick = $urandom_range(0, 2);
                enq_pct = (pick == 0) ? 85 : (pick == 1) ? 20 : 50;
            end
            seg_left--;
            if ($urandom_range(0, 99) < enq_pct) begin
                pick = $urandom_range(0, 99);
                lim = (slice > 16'd8000) ? 16'hFFFF : 16'(3 * slice + 2);
                if (pick < 60) begin
                    len = 16'($urandom_range(0, lim));
                end else if (pick < 75) begin
                    len = slice - 16'd1 + 16'($urandom_range(0, 2));
                end else if (pick < 85) begin
                    len = 16'($urandom);
                end else begin
                    len = 16'($urandom_range(0, 3));
                end
                add_job(ACT_ENQUEUE, len);
            end else begin
                add_job(ACT_RUN, 16'($urandom));
            end
            made++;
        end
    endtask

    task automatic wait_idle();
        do @(posedge aclk);
        while (job_stream.size() != 0 || s_tvalid || pending_results.size() != 0);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_quantum(logic [15:0] value);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        slice = value;
        repeat (2) @(posedge aclk);
    endtask

    initial begin
        logic [15:0] quanta [5];
        int          counts [5];
        quanta = '{16'd1, 16'hFFFF, 16'd0, 16'd1, 16'd3};
        counts = '{120, 120, 40, 120, 110};
        quanta[3] = 16'($urandom_range(1, 65535));

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        add_job(ACT_RUN, 16'hFFFF);
        add_job(ACT_ENQUEUE, 16'd7);
        add_job(ACT_ENQUEUE, 16'd0);
        add_job(ACT_ENQUEUE, 16'd5);
        add_job(ACT_ENQUEUE, 16'hFFFF);
        repeat (5) add_job(ACT_RUN, 16'h0000);
        for (int i = 1; i <= 15; i++) add_job(ACT_ENQUEUE, 16'(i));
        add_job(ACT_ENQUEUE, 16'd6);
        add_job(ACT_RUN, 16'h0000);
        add_random(140);
        wait_idle();

        for (int p = 0; p < 5; p++) begin
            write_quantum(quanta[p]);
            add_random(counts[p]);
            wait_idle();
        end

        repeat (10) @(posedge aclk);
        $display("Covered %0d input transfers over six quantum settings, including 0, 1 and 65535.",
                 inputs_taken);
        $display("Results seen: %0d enqueued, %0d rejected, %0d rotated, %0d finished, %0d empty.",
                 status_hits[ST_ENQUEUED], status_hits[ST_REJECTED], status_hits[ST_ROTATED],
                 status_hits[ST_FINISHED], status_hits[ST_EMPTY]);
        if (errors == 0 && pending_results.size() == 0) begin
            $display("round_robin_quantum_scheduler verification clean");
        end else begin
            $display("round_robin_quantum_scheduler verification failed");
        end
        $finish;
    end

endmodule

[round_robin_quantum_scheduler.f]
design/rrqs_pkg.sv
design/rrqs_cell.sv
design/round_robin_quantum_scheduler.sv
bench/round_robin_quantum_scheduler_tb.sv
